// ===== rtl/fca_pkg.sv =====
// Shared types and constants for the FAT16 cluster allocator.
package fca_pkg;

   localparam int DEFAULT_TABLE_ENTRIES = 256;

   localparam int ENTRY_W = 16;
   localparam int COUNT_W = 9;
   localparam int INDEX_W = 8;

   localparam logic [ENTRY_W-1:0] EOF_MARKER_RESET     = 16'd65528;
   localparam logic [COUNT_W-1:0] ENTRIES_IN_USE_RESET = 9'd256;

   localparam logic CSR_EOF_MARKER     = 1'b0;
   localparam logic CSR_ENTRIES_IN_USE = 1'b1;

   typedef enum logic [1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_WRITE = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2,
      STAT_LIMIT = 2'd3
   } status_type;

endpackage

// ===== rtl/fca_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fca_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

// ===== rtl/fat16_cluster_allocator.sv =====
// FAT16-style cluster allocation table: top level.
//
// Items arrive on the req_ channel (action, index, value) and each gives one
// result item on the rsp_ channel, both valid/ready. The table lives in one
// RAM with a registered read; actions run one at a time.
//   write entry : RAM write, then the output register
//   read entry  : RAM read, capture of the read data, then the output register
//   allocate    : scans entries from 0 for a zero one (at most the scan
//                 limit); one RAM read per cycle
//   free chain  : one entry cleared per cycle, read of the next link
//                 overlapping the clear of the current
// The scan limit is min(entries_in_use, TABLE_ENTRIES).
// After reset a clearing pass zeroes every table entry; no item is taken
// during it, configuration writes are. csr_ writes take effect at once; the
// user must make them only while the block is idle; it is not enforced.
// A result waiting on a stalled receiver holds in the output register; the
// next item is still accepted and runs, and its result waits for the slot.
module fat16_cluster_allocator #(
   parameter int TABLE_ENTRIES = fca_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_index,
   input  logic [15:0] req_value,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_result_cluster,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_read_value,
   output logic [8:0]  rsp_freed_count,

   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam logic [15:0] TE16 = 16'(TABLE_ENTRIES);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ALLOC,
      S_FREE,
      S_READ,
      S_POST
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] cur_ff, cur_in;
   logic [8:0]  steps_ff, steps_in;
   logic        primed_ff, primed_in;
   logic        fwd_ff, fwd_in;
   logic [15:0] eof_ff;
   logic [8:0]  eiu_ff;

   logic [7:0]  res_cluster_ff, res_cluster_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic [15:0] res_rd_ff, res_rd_in;
   logic [8:0]  res_freed_ff, res_freed_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_cluster_ff, rsp_cluster_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_rd_ff, rsp_rd_in;
   logic [8:0]  rsp_freed_ff, rsp_freed_in;

   logic          we, re;
   logic [AW-1:0] waddr, raddr;
   logic [15:0]   wdata, rdata;

   logic [8:0]  n_lim;
   logic [15:0] n16, idx16, prev16, link16;
   logic [8:0]  steps_nx;
   logic        idx_ok;

   fca_ram #(
      .WIDTH (fca_pkg::ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign n_lim    = ({7'd0, eiu_ff} > TE16) ? TE16[8:0] : eiu_ff;
   assign n16      = {7'd0, n_lim};
   assign idx16    = {8'd0, req_index};
   assign idx_ok   = idx16 < TE16;
   assign prev16   = cur_ff - 16'd1;
   assign link16   = fwd_ff ? 16'd0 : rdata;
   assign steps_nx = steps_ff + 9'd1;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      steps_in       = steps_ff;
      primed_in      = primed_ff;
      fwd_in         = 1'b0;
      res_cluster_in = res_cluster_ff;
      res_status_in  = res_status_ff;
      res_rd_in      = res_rd_ff;
      res_freed_in   = res_freed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_cluster_in = rsp_cluster_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_rd_in      = rsp_rd_ff;
      rsp_freed_in   = rsp_freed_ff;
      we    = 1'b0;
      re    = 1'b0;
      waddr = cur_ff[AW-1:0];
      wdata = 16'd0;
      raddr = cur_ff[AW-1:0];

      case (state_ff)
         S_CLEAR: begin
            we = 1'b1;
            if (cur_ff == TE16 - 16'd1) begin
               cur_in   = 16'd0;
               state_in = S_IDLE;
            end else begin
               cur_in = cur_ff + 16'd1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               res_cluster_in = 8'd0;
               res_rd_in      = 16'd0;
               res_freed_in   = 9'd0;
               res_status_in  = fca_pkg::STAT_OK;
               state_in       = S_POST;
               case (req_action)
                  fca_pkg::ACT_ALLOC: begin
                     cur_in    = 16'd0;
                     primed_in = 1'b0;
                     if (n_lim == 9'd0) begin
                        res_status_in = fca_pkg::STAT_FULL;
                     end else begin
                        state_in = S_ALLOC;
                     end
                  end
                  fca_pkg::ACT_FREE: begin
                     cur_in   = idx16;
                     steps_in = 9'd0;
                     if (idx16 >= eof_ff) begin
                        res_status_in = fca_pkg::STAT_OK;
                     end else if (idx16 >= n16) begin
                        res_status_in = fca_pkg::STAT_RANGE;
                     end else begin
                        re       = 1'b1;
                        raddr    = idx16[AW-1:0];
                        state_in = S_FREE;
                     end
                  end
                  fca_pkg::ACT_WRITE: begin
                     if (idx_ok) begin
                        we    = 1'b1;
                        waddr = idx16[AW-1:0];
                        wdata = req_value;
                     end else begin
                        res_status_in = fca_pkg::STAT_RANGE;
                     end
                  end
                  default: begin
                     if (idx_ok) begin
                        re       = 1'b1;
                        raddr    = idx16[AW-1:0];
                        state_in = S_READ;
                     end else begin
                        res_status_in = fca_pkg::STAT_RANGE;
                     end
                  end
               endcase
            end
         end
         S_ALLOC: begin
            if (primed_ff && rdata == 16'd0) begin
               we             = 1'b1;
               waddr          = prev16[AW-1:0];
               wdata          = eof_ff;
               res_cluster_in = prev16[7:0];
               res_status_in  = fca_pkg::STAT_OK;
               state_in       = S_POST;
            end else if (cur_ff == n16) begin
               res_status_in = fca_pkg::STAT_FULL;
               state_in      = S_POST;
            end else begin
               re        = 1'b1;
               raddr     = cur_ff[AW-1:0];
               cur_in    = cur_ff + 16'd1;
               primed_in = 1'b1;
            end
         end
         S_FREE: begin
            // clear the current entry while the next link is fetched
            we           = 1'b1;
            steps_in     = steps_nx;
            res_freed_in = steps_nx;
            cur_in       = link16;
            if (link16 >= eof_ff) begin
               res_status_in = fca_pkg::STAT_OK;
               state_in      = S_POST;
            end else if (link16 >= n16) begin
               res_status_in = fca_pkg::STAT_RANGE;
               state_in      = S_POST;
            end else if (steps_nx == n_lim) begin
               res_status_in = fca_pkg::STAT_LIMIT;
               state_in      = S_POST;
            end else begin
               re     = 1'b1;
               raddr  = link16[AW-1:0];
               fwd_in = (link16 == cur_ff);
            end
         end
         S_READ: begin
            res_rd_in     = rdata;
            res_status_in = fca_pkg::STAT_OK;
            state_in      = S_POST;
         end
         S_POST: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_cluster_in = res_cluster_ff;
               rsp_status_in  = res_status_ff;
               rsp_rd_in      = res_rd_ff;
               rsp_freed_in   = res_freed_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cur_ff       <= 16'd0;
         steps_ff     <= 9'd0;
         primed_ff    <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         eof_ff       <= fca_pkg::EOF_MARKER_RESET;
         eiu_ff       <= fca_pkg::ENTRIES_IN_USE_RESET;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         steps_ff     <= steps_in;
         primed_ff    <= primed_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               fca_pkg::CSR_EOF_MARKER:     eof_ff <= csr_wdata;
               fca_pkg::CSR_ENTRIES_IN_USE: eiu_ff <= csr_wdata[8:0];
               default: ;
            endcase
         end
      end
      res_cluster_ff <= res_cluster_in;
      res_status_ff  <= res_status_in;
      res_rd_ff      <= res_rd_in;
      res_freed_ff   <= res_freed_in;
      rsp_cluster_ff <= rsp_cluster_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_rd_ff      <= rsp_rd_in;
      rsp_freed_ff   <= rsp_freed_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_cluster = rsp_cluster_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_value     = rsp_rd_ff;
   assign rsp_freed_count    = rsp_freed_ff;

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_ready)
      else $error("item accepted during clearing pass");

   a_same_addr_fwd: assert property (@(posedge clock) disable iff (reset)
      we && re && waddr == raddr |=> fwd_ff)
      else $error("read of entry being written without forwarding");

   a_fwd_in_free: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> state_ff == S_FREE)
      else $error("forward flag outside chain walk");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == fca_pkg::STAT_FULL |->
         rsp_result_cluster == 8'd0 && rsp_freed_count == 9'd0)
      else $error("no-free-entry result carries cluster or count");

endmodule

// ===== sim/tb_fat16_cluster_allocator.sv =====
// Self-checking testbench for the FAT16 cluster allocator.
`timescale 1ns / 100ps

module tb_fat16_cluster_allocator;

   typedef struct {
      logic [7:0]          cluster;
      fca_pkg::status_type status;
      logic [15:0]         rd;
      logic [8:0]          freed;
   } fat_answer_type;

   // shadow of the cluster table; predicts one answer per item
   class cluster_table_shadow_type;
      logic [15:0] entry [fca_pkg::DEFAULT_TABLE_ENTRIES];
      logic [15:0] eof_value;
      logic [8:0]  in_use;
      fat_answer_type awaited [$];
      int errors;
      int accepted;
      int act_count [4];
      int stat_count [4];

      function new();
         foreach (entry[i]) entry[i] = '0;
         eof_value = fca_pkg::EOF_MARKER_RESET;
         in_use = fca_pkg::ENTRIES_IN_USE_RESET;
         errors = 0;
         accepted = 0;
         foreach (act_count[i]) act_count[i] = 0;
         foreach (stat_count[i]) stat_count[i] = 0;
      endfunction

      function void set_reg(logic idx, logic [15:0] data);
         if (idx == fca_pkg::CSR_EOF_MARKER) eof_value = data;
         else in_use = data[8:0];
      endfunction

      function int unsigned scan_limit();
         return (in_use > fca_pkg::DEFAULT_TABLE_ENTRIES) ?
                fca_pkg::DEFAULT_TABLE_ENTRIES : 32'(in_use);
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void take_request(fca_pkg::action_type act, logic [7:0] idx,
                                 logic [15:0] val);
         fat_answer_type a;
         int unsigned n;
         int unsigned cur;
         int unsigned steps;
         int unsigned i;
         n = scan_limit();
         a.cluster = '0;
         a.status = fca_pkg::STAT_OK;
         a.rd = '0;
         a.freed = '0;
         case (act)
            fca_pkg::ACT_ALLOC: begin
               a.status = fca_pkg::STAT_FULL;
               for (i = 0; i < n; i++) begin
                  if (entry[i] == 16'd0) begin
                     entry[i] = eof_value;
                     a.cluster = 8'(i);
                     a.status = fca_pkg::STAT_OK;
                     break;
                  end
               end
            end
            fca_pkg::ACT_FREE: begin
               cur = 32'(idx);
               steps = 0;
               while (1) begin
                  if (cur >= 32'(eof_value)) begin
                     a.status = fca_pkg::STAT_OK;
                     break;
                  end
                  if (cur >= n) begin
                     a.status = fca_pkg::STAT_RANGE;
                     break;
                  end
                  if (steps >= n) begin
                     a.status = fca_pkg::STAT_LIMIT;
                     break;
                  end
                  i = cur;
                  cur = 32'(entry[i]);
                  entry[i] = '0;
                  a.freed++;
                  steps++;
               end
            end
            fca_pkg::ACT_WRITE: entry[idx] = val;
            default: a.rd = entry[idx];
         endcase
         accepted++;
         act_count[act]++;
         stat_count[a.status]++;
         awaited.push_back(a);
      endfunction

      task report(string msg);
         errors++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task match_response(logic [7:0] cl, logic [1:0] st, logic [15:0] rd, logic [8:0] fr);
         fat_answer_type a;
         if (awaited.size() == 0) begin
            report("result item with no item outstanding");
            return;
         end
         a = awaited.pop_front();
         if (cl !== a.cluster)
            report($sformatf("result_cluster %0d, expected %0d", cl, a.cluster));
         if (st !== a.status)
            report($sformatf("status %0d, expected %0d", st, a.status));
         if (rd !== a.rd)
            report($sformatf("read_value %0h, expected %0h", rd, a.rd));
         if (fr !== a.freed)
            report($sformatf("freed_count %0d, expected %0d", fr, a.freed));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_action;
   logic [7:0]  req_index;
   logic [15:0] req_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_result_cluster;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_read_value;
   logic [8:0]  rsp_freed_count;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   cluster_table_shadow_type sb;
   int items_sent = 0;
   int burst_left = 0;
   int hold_left = 0;
   int holds_done = 0;
   int settings_used = 0;
   bit no_gaps = 1'b0;

   fat16_cluster_allocator i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_index          (req_index),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_cluster (rsp_result_cluster),
      .rsp_status         (rsp_status),
      .rsp_read_value     (rsp_read_value),
      .rsp_freed_count    (rsp_freed_count),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.match_response(rsp_result_cluster, rsp_status, rsp_read_value,
                              rsp_freed_count);
         if (req_valid && req_ready)
            sb.take_request(fca_pkg::action_type'(req_action), req_index, req_value);
      end
   end

   // receiver: random stall rate that changes now and then, plus two long holds
   initial begin
      int cycle;
      int stall_pct;
      cycle = 0;
      stall_pct = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         cycle++;
         if (hold_left == 0 && holds_done < 2 &&
             sb.accepted >= ((holds_done == 0) ? 80 : 330)) begin
            hold_left = 500;
            holds_done++;
         end
         if (cycle % 150 == 0) begin
            case ($urandom_range(0, 4))
               0, 1: stall_pct = 0;
               2: stall_pct = 25;
               3: stall_pct = 60;
               default: stall_pct = 90;
            endcase
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   task automatic send_item(fca_pkg::action_type act, logic [7:0] idx, logic [15:0] val);
      int gap;
      if (burst_left == 0) begin
         gap = (no_gaps || hold_left > 0) ? 0 : $urandom_range(1, 10);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_action <= act;
      req_index <= idx;
      req_value <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic csr_write(logic idx, logic [15:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_reg(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(logic [15:0] eof, int eiu);
      csr_write(fca_pkg::CSR_EOF_MARKER, eof);
      csr_write(fca_pkg::CSR_ENTRIES_IN_USE, 16'(eiu));
      settings_used++;
   endtask

   // half the draws are chains built by writes then freed (some broken), the rest noise
   task automatic run_random_phase(int quota);
      int first;
      int n;
      int r;
      int len;
      int k;
      int j;
      int tmp;
      int tail;
      int eof;
      int order [256];
      first = items_sent;
      n = int'(sb.scan_limit());
      eof = int'(sb.eof_value);
      while (items_sent - first < quota) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            if (n <= 32 && $urandom_range(0, 9) == 0) len = $urandom_range(1, n);
            else len = $urandom_range(1, (n < 8) ? n : 8);
            for (k = 0; k < n; k++) order[k] = k;
            for (k = 0; k < len; k++) begin
               j = $urandom_range(k, n - 1);
               tmp = order[k];
               order[k] = order[j];
               order[j] = tmp;
            end
            if (r < 35) begin
               tail = $urandom_range(eof, 65535);
            end else begin
               case ($urandom_range(0, 2))
                  0: tail = (n < eof) ? $urandom_range(n, eof - 1) : order[0];
                  1: tail = 0;
                  default: tail = order[$urandom_range(0, len - 1)];
               endcase
            end
            for (k = 0; k < len - 1; k++)
               send_item(fca_pkg::ACT_WRITE, 8'(order[k]), 16'(order[k + 1]));
            send_item(fca_pkg::ACT_WRITE, 8'(order[len - 1]), 16'(tail));
            if ($urandom_range(0, 3) == 0)
               send_item(fca_pkg::ACT_READ, 8'(order[$urandom_range(0, len - 1)]),
                         16'($urandom));
            send_item(fca_pkg::ACT_FREE, 8'(order[0]), 16'($urandom));
         end else if (r < 65) begin
            repeat ($urandom_range(1, 6))
               send_item(fca_pkg::ACT_ALLOC, 8'($urandom), 16'($urandom));
         end else if (r < 80) begin
            send_item(fca_pkg::ACT_READ, 8'($urandom_range(0, n - 1)), 16'($urandom));
         end else begin
            send_item(fca_pkg::action_type'($urandom_range(0, 3)), 8'($urandom),
                      16'($urandom));
         end
      end
   endtask

   initial begin
      int p;
      int eiu;
      logic [15:0] eof;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = fca_pkg::ACT_ALLOC;
      req_index = '0;
      req_value = '0;
      csr_we = 1'b0;
      csr_index = fca_pkg::CSR_EOF_MARKER;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: first allocations, links, free, step limit, out of range link
      send_item(fca_pkg::ACT_READ, 8'd0, 16'hFFFF);
      send_item(fca_pkg::ACT_ALLOC, 8'd0, 16'd0);
      send_item(fca_pkg::ACT_ALLOC, 8'hFF, 16'hFFFF);
      send_item(fca_pkg::ACT_WRITE, 8'd255, 16'hFFFF);
      send_item(fca_pkg::ACT_READ, 8'd255, 16'd0);
      send_item(fca_pkg::ACT_WRITE, 8'd1, 16'd2);
      send_item(fca_pkg::ACT_ALLOC, 8'd0, 16'd0);
      send_item(fca_pkg::ACT_FREE, 8'd1, 16'd0);
      send_item(fca_pkg::ACT_FREE, 8'd0, 16'd0);
      send_item(fca_pkg::ACT_FREE, 8'd0, 16'd0);
      send_item(fca_pkg::ACT_WRITE, 8'd5, 16'd300);
      send_item(fca_pkg::ACT_FREE, 8'd5, 16'd0);
      send_item(fca_pkg::ACT_READ, 8'd5, 16'd0);
      send_item(fca_pkg::ACT_WRITE, 8'd0, 16'd0);
      wait_idle();

      // four entries: fill up, then access above the scanned range
      set_config(16'd65535, 4);
      repeat (5) send_item(fca_pkg::ACT_ALLOC, 8'd0, 16'd0);
      send_item(fca_pkg::ACT_WRITE, 8'd200, 16'd7);
      send_item(fca_pkg::ACT_READ, 8'd200, 16'd0);
      send_item(fca_pkg::ACT_FREE, 8'd200, 16'd0);
      wait_idle();

      // lowest settings: start at or above marker, single entry table
      set_config(16'd1, 1);
      send_item(fca_pkg::ACT_FREE, 8'd5, 16'd0);
      send_item(fca_pkg::ACT_FREE, 8'd0, 16'd0);
      send_item(fca_pkg::ACT_ALLOC, 8'd0, 16'd0);
      send_item(fca_pkg::ACT_ALLOC, 8'd0, 16'd0);

      for (p = 0; p < 8; p++) begin
         wait_idle();
         case (p)
            0: begin eof = 16'd65535; eiu = 256; end
            1: begin eof = 16'd1; eiu = 1; end
            2: begin eof = 16'd16; eiu = 8; end
            3: begin eof = 16'd300; eiu = 32; end
            4: begin eof = fca_pkg::EOF_MARKER_RESET; eiu = 256; end
            default: begin
               eof = 16'($urandom_range(0, 1) ? $urandom_range(1, 400) :
                                                $urandom_range(1, 65535));
               eiu = $urandom_range(1, 256);
            end
         endcase
         set_config(eof, eiu);
         no_gaps = (p == 3);
         run_random_phase(60);
      end
      no_gaps = 1'b0;
      wait_idle();
      repeat (300) @(posedge clock);

      $display("Ran %0d items under %0d register settings: %0d allocate, %0d free chain,",
               sb.accepted, settings_used + 1, sb.act_count[fca_pkg::ACT_ALLOC],
               sb.act_count[fca_pkg::ACT_FREE]);
      $display("  %0d write, %0d read; %0d ok, %0d full, %0d out of range, %0d step limit.",
               sb.act_count[fca_pkg::ACT_WRITE], sb.act_count[fca_pkg::ACT_READ],
               sb.stat_count[fca_pkg::STAT_OK], sb.stat_count[fca_pkg::STAT_FULL],
               sb.stat_count[fca_pkg::STAT_RANGE], sb.stat_count[fca_pkg::STAT_LIMIT]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
